// ===== hdl/osc52_pkg.sv =====
// Shared types, character constants and lookup functions for the OSC 52 emitter.
`timescale 1ns / 1ps

package osc52_pkg;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	localparam logic [2:0] PREFIX_LAST = 3'd6;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
	} chr_item_t;

	typedef enum logic [2:0] {
		BODY_NONE,
		BODY_QUERY,
		BODY_FULL,
		BODY_TAIL1,
		BODY_TAIL2
	} body_kind_t;

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_BODY,
		PH_TERM
	} phase_t;

	// One queued job: what the back end has to emit for one input transaction
	typedef struct packed {
		logic        has_prefix;
		body_kind_t  body;
		logic [23:0] triple;
		logic        has_term;
	} job_t;

	// Map a six-bit value to its base64 character
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'h41 + w;
		end else if (v < 6'd52) begin
			return 8'h61 + (w - 8'd26);
		end else if (v < 6'd62) begin
			return 8'h30 + (w - 8'd52);
		end else if (v == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

	// Character at a position of the sequence ESC ] 5 2 ; c ;
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = CH_ESC;
			3'd1: c = 8'h5D;
			3'd2: c = 8'h35;
			3'd3: c = 8'h32;
			3'd4: c = 8'h3B;
			3'd5: c = 8'h63;
			3'd6: c = 8'h3B;
			default: c = CH_ESC;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/osc52_front.sv =====
// Front end: accepts transactions, tracks message state and builds emit jobs.
`timescale 1ns / 1ps

module osc52_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_stall,
	input  osc52_pkg::msg_item_t msg,
	input  logic                q_full,
	output logic                push,
	output osc52_pkg::job_t     push_job
);
	import osc52_pkg::*;

	logic        open_q;
	logic [1:0]  held_cnt_q;
	logic [15:0] held_q;

	logic        open_n;
	logic [1:0]  held_cnt_n;
	logic [15:0] held_n;
	logic        accept;
	job_t        job;

	assign msg_stall = q_full;
	assign accept    = msg_valid && !q_full;

	// Classify the transaction and work out the next message state
	always_comb begin
		open_n     = open_q;
		held_cnt_n = held_cnt_q;
		held_n     = held_q;
		job        = '{has_prefix: 1'b0, body: BODY_NONE, triple: 24'h0, has_term: 1'b0};
		if (msg.action) begin
			// drop a request inside an open message
			if (!open_q) begin
				job.has_prefix = 1'b1;
				job.body       = BODY_QUERY;
				job.has_term   = 1'b1;
			end
		end else begin
			if (!open_q) begin
				job.has_prefix = 1'b1;
				open_n         = 1'b1;
				held_cnt_n     = 2'd0;
				held_n         = 16'h0;
			end
			if (held_cnt_n >= 2'd2) begin
				job.body   = BODY_FULL;
				job.triple = {held_n, msg.data_byte};
				held_cnt_n = 2'd0;
				held_n     = 16'h0;
			end else if (held_cnt_n == 2'd1) begin
				held_n     = {held_n[15:8], msg.data_byte};
				held_cnt_n = 2'd2;
			end else begin
				held_n     = {msg.data_byte, 8'h00};
				held_cnt_n = 2'd1;
			end
			if (msg.end_of_message) begin
				if (held_cnt_n == 2'd1) begin
					job.body   = BODY_TAIL1;
					job.triple = {held_n, 8'h00};
				end else if (held_cnt_n >= 2'd2) begin
					job.body   = BODY_TAIL2;
					job.triple = {held_n, 8'h00};
				end
				job.has_term = 1'b1;
				open_n       = 1'b0;
				held_cnt_n   = 2'd0;
				held_n       = 16'h0;
			end
		end
	end

	assign push     = accept && (job.has_prefix || job.has_term || job.body != BODY_NONE);
	assign push_job = job;

	// Advance message state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			held_cnt_q <= 2'd0;
			held_q     <= 16'h0;
		end else if (accept) begin
			open_q     <= open_n;
			held_cnt_q <= held_cnt_n;
			held_q     <= held_n;
		end
	end

endmodule

// ===== hdl/osc52_fifo.sv =====
// Small job queue between the front and back ends.
`timescale 1ns / 1ps

module osc52_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  osc52_pkg::job_t push_job,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output osc52_pkg::job_t head_job
);
	import osc52_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("job queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("job queue count out of range");
`endif

endmodule

// ===== hdl/osc52_back.sv =====
// Back end: walks each queued job and emits one character per cycle while the output is not stalled.
`timescale 1ns / 1ps

module osc52_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  osc52_pkg::job_t       head_job,
	output logic                  pop,
	output logic                  chr_valid,
	input  logic                  chr_stall,
	output osc52_pkg::chr_item_t  chr
);
	import osc52_pkg::*;

	phase_t     phase_q;
	logic [2:0] cnt_q;
	logic       started_q;
	logic       chr_valid_q;
	chr_item_t  chr_q;

	phase_t     phase_cur;
	logic [2:0] cnt_cur;
	phase_t     phase_n;
	logic [2:0] cnt_n;
	logic       started_n;
	logic       emit;
	logic       done;
	logic       body_end;
	logic [5:0] sextet;
	logic [7:0] char_cur;

	assign emit = head_valid && (!chr_valid_q || !chr_stall);

	// Pick the position, the character and the next position
	always_comb begin
		if (started_q) begin
			phase_cur = phase_q;
			cnt_cur   = cnt_q;
		end else begin
			cnt_cur = 3'd0;
			if (head_job.has_prefix) begin
				phase_cur = PH_PREFIX;
			end else if (head_job.body != BODY_NONE) begin
				phase_cur = PH_BODY;
			end else begin
				phase_cur = PH_TERM;
			end
		end

		unique case (cnt_cur[1:0])
			2'd0: sextet = head_job.triple[23:18];
			2'd1: sextet = head_job.triple[17:12];
			2'd2: sextet = head_job.triple[11:6];
			default: sextet = head_job.triple[5:0];
		endcase

		body_end = (head_job.body == BODY_QUERY) ? 1'b1 : (cnt_cur == 3'd3);

		phase_n  = phase_cur;
		cnt_n    = cnt_cur + 3'd1;
		done     = 1'b0;
		char_cur = CH_PAD;
		unique case (phase_cur)
			PH_PREFIX: begin
				char_cur = prefix_char(cnt_cur);
				if (cnt_cur == PREFIX_LAST) begin
					cnt_n = 3'd0;
					if (head_job.body != BODY_NONE) begin
						phase_n = PH_BODY;
					end else if (head_job.has_term) begin
						phase_n = PH_TERM;
					end else begin
						done = 1'b1;
					end
				end
			end
			PH_BODY: begin
				unique case (head_job.body)
					BODY_QUERY: char_cur = CH_QUERY;
					BODY_FULL:  char_cur = b64_char(sextet);
					BODY_TAIL1: char_cur = (cnt_cur < 3'd2) ? b64_char(sextet) : CH_PAD;
					BODY_TAIL2: char_cur = (cnt_cur < 3'd3) ? b64_char(sextet) : CH_PAD;
					default:    char_cur = CH_PAD;
				endcase
				if (body_end) begin
					cnt_n = 3'd0;
					if (head_job.has_term) begin
						phase_n = PH_TERM;
					end else begin
						done = 1'b1;
					end
				end
			end
			PH_TERM: begin
				char_cur = (cnt_cur == 3'd0) ? CH_ESC : CH_BSL;
				if (cnt_cur != 3'd0) begin
					done = 1'b1;
				end
			end
			default: begin
				char_cur = CH_PAD;
				done     = 1'b1;
			end
		endcase

		started_n = !done;
	end

	assign pop = emit && done;

	// Hold the walk position within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PREFIX;
			cnt_q     <= 3'd0;
			started_q <= 1'b0;
		end else if (emit) begin
			phase_q   <= phase_n;
			cnt_q     <= cnt_n;
			started_q <= started_n;
		end
	end

	// Output register: load whenever empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_valid_q <= 1'b0;
		end else if (!chr_valid_q || !chr_stall) begin
			chr_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			chr_q.out_char <= char_cur;
			chr_q.run_last <= done;
		end
	end

	assign chr_valid = chr_valid_q;
	assign chr       = chr_q;

`ifndef SYNTH
	a_started_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> head_valid)
		else $error("walk in progress without a queued job");
	a_term_second: assert property (@(posedge clk) disable iff (!arst_n)
		(started_q && phase_q == PH_TERM) |-> (cnt_q <= 3'd1))
		else $error("terminator resumed at wrong position");
	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && done) |=> (chr_valid_q && chr_q.run_last && !started_q))
		else $error("final character not flagged");
`endif

endmodule

// ===== hdl/osc52_base64_clipboard_emitter.sv =====
// Top level of the OSC 52 clipboard sequence emitter with streaming base64.
// A transaction's first character passes through the job queue and the output register.
// One character per cycle from the back end's sequencer while a job is queued and chr_stall
//   is low; a message is about 4/3 chars per byte plus 9 for prefix and terminator, a query 10.
// Input is accepted every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset (arst_n low) clears message state, the queue and the output register at once.
`timescale 1ns / 1ps

module osc52_base64_clipboard_emitter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_stall,
	input  osc52_pkg::msg_item_t msg,
	output logic                 chr_valid,
	input  logic                 chr_stall,
	output osc52_pkg::chr_item_t chr
);
	import osc52_pkg::*;

	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	osc52_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg      (msg),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	osc52_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	osc52_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_job  (head_job),
		.pop       (pop),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr)
	);

endmodule

// ===== bench/tb_osc52_base64_clipboard_emitter.sv =====
// Self-checking testbench for the OSC 52 base64 clipboard emitter.
`timescale 1ns / 1ps

module tb_osc52_base64_clipboard_emitter;
	import osc52_pkg::*;

	localparam logic ACT_DATA  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 25;

	localparam string B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam string HEAD_TEXT = "]52;c;";

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      msg_valid = 1'b0;
	logic      msg_stall;
	msg_item_t msg       = '0;
	logic      chr_valid;
	logic      chr_stall = 1'b0;
	chr_item_t chr;

	// Encoder state mirrored by the predictor
	logic        msg_open  = 1'b0;
	logic [1:0]  held_cnt  = 2'd0;
	logic [15:0] held_data = 16'd0;

	msg_item_t pending   [$];
	chr_item_t chars_due [$];

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_reqs      = 0;
	int   hold_done      = 0;
	int   hold_left      = 0;
	int   mismatches     = 0;
	int   quiet_cycles   = 0;
	logic in_fire        = 1'b0;

	osc52_base64_clipboard_emitter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic push_char(input logic [7:0] c);
		chars_due.push_back('{c, 1'b0});
	endtask

	task automatic push_sextet(input logic [5:0] v);
		push_char(B64_ALPHABET.getc(v));
	endtask

	task automatic push_head();
		push_char(CH_ESC);
		for (int i = 0; i < HEAD_TEXT.len(); i++) begin
			push_char(HEAD_TEXT.getc(i));
		end
	endtask

	task automatic push_term();
		push_char(CH_ESC);
		push_char(CH_BSL);
	endtask

	// Work out the characters one accepted transaction must produce
	task automatic encode_item(input msg_item_t it);
		int          first;
		logic [23:0] grp;
		chr_item_t   tail_c;
		first = chars_due.size();
		if (it.action == ACT_QUERY) begin
			// drop a query that lands inside an open message
			if (!msg_open) begin
				push_head();
				push_char(CH_QUERY);
				push_term();
			end
		end else begin
			if (!msg_open) begin
				push_head();
				msg_open  = 1'b1;
				held_cnt  = 2'd0;
				held_data = 16'd0;
			end
			if (held_cnt >= 2'd2) begin
				grp = {held_data, it.data_byte};
				push_sextet(grp[23:18]);
				push_sextet(grp[17:12]);
				push_sextet(grp[11:6]);
				push_sextet(grp[5:0]);
				held_cnt  = 2'd0;
				held_data = 16'd0;
			end else if (held_cnt == 2'd1) begin
				held_data[7:0] = it.data_byte;
				held_cnt       = 2'd2;
			end else begin
				held_data = {it.data_byte, 8'h00};
				held_cnt  = 2'd1;
			end
			if (it.end_of_message) begin
				// flush the partial group with padding, then terminate
				grp = {held_data, 8'h00};
				if (held_cnt == 2'd1) begin
					push_sextet(grp[23:18]);
					push_sextet(grp[17:12]);
					push_char(CH_PAD);
					push_char(CH_PAD);
				end else if (held_cnt >= 2'd2) begin
					push_sextet(grp[23:18]);
					push_sextet(grp[17:12]);
					push_sextet(grp[11:6]);
					push_char(CH_PAD);
				end
				push_term();
				msg_open  = 1'b0;
				held_cnt  = 2'd0;
				held_data = 16'd0;
			end
		end
		// mark the final character of this transaction
		if (chars_due.size() > first) begin
			tail_c          = chars_due.pop_back();
			tail_c.run_last = 1'b1;
			chars_due.push_back(tail_c);
		end
	endtask

	task automatic add_item(input logic act, input logic [7:0] b, input logic eom);
		msg_item_t it;
		it.action         = act;
		it.data_byte      = b;
		it.end_of_message = eom;
		pending.push_back(it);
	endtask

	// Mostly well-formed messages with random bytes, plus queries and noise
	task automatic queue_random_traffic(input int n_items);
		int   counted;
		int   len;
		int   r;
		logic gen_open;
		logic act;
		logic eom;
		counted  = 0;
		gen_open = 1'b0;
		while (counted < n_items) begin
			r = $urandom_range(99);
			if (r < 70) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(9) == 0) begin
						add_item(ACT_QUERY, 8'($urandom), 1'($urandom));
					end
					add_item(ACT_DATA, 8'($urandom), i == len - 1);
					counted++;
				end
				gen_open = 1'b0;
			end else if (r < 85) begin
				add_item(ACT_QUERY, 8'($urandom), 1'($urandom));
				if (!gen_open) begin
					counted++;
				end
			end else begin
				act = 1'($urandom);
				eom = ($urandom_range(3) == 0);
				add_item(act, 8'($urandom), eom);
				if (act == ACT_DATA || !gen_open) begin
					counted++;
				end
				if (act == ACT_DATA) begin
					gen_open = !eom;
				end
			end
		end
	endtask

	// Offer the next transaction once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!msg_valid || in_fire)) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				msg       <= pending.pop_front();
				msg_valid <= 1'b1;
			end else begin
				msg_valid <= 1'b0;
			end
		end
	end

	// Stall the output at random, or hold it off for a long stretch on request
	always @(negedge clk) begin
		if (hold_done != hold_reqs) begin
			hold_done = hold_reqs;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			chr_stall <= 1'b1;
		end else begin
			chr_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Check accepted characters, predict accepted input, watch for hangs
	always @(posedge clk) begin
		chr_item_t want;
		logic      out_fire;
		if (arst_n) begin
			in_fire  = msg_valid && !msg_stall;
			out_fire = chr_valid && !chr_stall;
			if (out_fire) begin
				if (chars_due.size() == 0) begin
					report_mismatch("unexpected character", chr.out_char, 8'h00);
				end else begin
					want = chars_due.pop_front();
					if (chr.out_char !== want.out_char) begin
						report_mismatch("out_char", chr.out_char, want.out_char);
					end
					if (chr.run_last !== want.run_last) begin
						report_mismatch("run_last", 8'(chr.run_last), 8'(want.run_last));
					end
				end
			end
			if (in_fire) begin
				encode_item(msg);
			end
			quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int send_tab [4];
		int stall_tab [4];
		send_tab  = '{0, 59, 0, 24};
		stall_tab = '{0, 0, 59, 24};

		// Directed: padding cases, full groups, '+' and '/', dropped query
		add_item(ACT_QUERY, 8'hFF, 1'b1);
		add_item(ACT_DATA, 8'h00, 1'b1);
		add_item(ACT_DATA, 8'hFF, 1'b1);
		add_item(ACT_DATA, 8'hFF, 1'b0);
		add_item(ACT_DATA, 8'hFF, 1'b1);
		add_item(ACT_DATA, 8'hFF, 1'b0);
		add_item(ACT_DATA, 8'hFF, 1'b0);
		add_item(ACT_DATA, 8'hFF, 1'b1);
		add_item(ACT_DATA, 8'hFB, 1'b0);
		add_item(ACT_DATA, 8'hEF, 1'b0);
		add_item(ACT_DATA, 8'hBE, 1'b1);
		add_item(ACT_DATA, 8'h12, 1'b0);
		add_item(ACT_QUERY, 8'h00, 1'b0);
		add_item(ACT_DATA, 8'h34, 1'b1);
		add_item(ACT_DATA, 8'h4D, 1'b0);
		add_item(ACT_DATA, 8'h61, 1'b0);
		add_item(ACT_DATA, 8'h6E, 1'b0);
		add_item(ACT_DATA, 8'h2E, 1'b1);
		add_item(ACT_QUERY, 8'hA5, 1'b0);
		add_item(ACT_DATA, 8'h80, 1'b0);
		add_item(ACT_DATA, 8'h01, 1'b0);
		add_item(ACT_DATA, 8'h7F, 1'b0);
		add_item(ACT_DATA, 8'hFE, 1'b0);
		add_item(ACT_DATA, 8'h00, 1'b1);

		// Release reset on a falling clock edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending.size() != 0) @(negedge clk);

		// Random traffic under each idling mix; long output hold in the first
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_tab[ph];
			recv_stall_pct = stall_tab[ph];
			if (ph == 0) begin
				hold_reqs++;
			end
			queue_random_traffic(PHASE_ITEMS);
			while (pending.size() != 0) @(negedge clk);
		end

		// Drain: last transaction taken and every character seen
		while (msg_valid || chars_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && chars_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
